FILE: hw/rtl/triuh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triuh_pkg
// Shared constants and helpers for the triangular unit hydrograph router.
// ----------------------------------------------------------------------------
package triuh_pkg;

   localparam int MAX_SLOTS_DEF = 128;

   localparam int AMT_W    = 32;
   localparam int MAXBAS_W = 16;
   localparam int STEP_W   = 24;
   localparam int WGT_W    = 17;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 24;

   localparam logic [MAXBAS_W-1:0] MAXBAS_RESET = 16'd256;
   localparam logic [STEP_W-1:0]   STEP_RESET   = 24'd65536;
   localparam logic [STEP_W-1:0]   STEP_ONE_DAY = 24'd65536;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAXBAS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP   = 8'd1;

   // item kinds
   localparam logic REQ_QUERY   = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   // clamp a wide signed sum to the 32-bit range
   function automatic logic signed [AMT_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         sat32 = 32'sh7fffffff;
      end else if (v < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[AMT_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/triangular_uh_routing_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangular_uh_routing_top
// Routing store with a triangular unit hydrograph schedule.
// ----------------------------------------------------------------------------
// One word at a time. A rate query runs S_Q_MUL, S_Q_ADD and S_DONE; the next
// word can be taken back in S_IDLE. An end-of-step advance runs S_A_IN, S_A_C0
// and S_A_C1, then one shared multiplier walks the schedule RAM one slot per
// S_A_RD, S_A_MUL, S_A_WR round, then S_A_LAST, S_A_FIN and S_DONE. A register
// write rebuilds the weights with a bit-serial divider: a division for the
// triangle base, S_RB_DW, S_RB_SQ, S_RB_C and S_RB_W for each slot inside the
// triangle except the last one, S_RB_W alone for that last slot and a clear
// in S_RB_J for each slot beyond the triangle. After reset the same pass, with
// the reset registers, also clears every schedule slot before the first word
// is accepted. A result may wait on rsp_ready while the next word runs; the
// block then holds in its last state until the output register is free.
module triangular_uh_routing_top #(
   parameter int MAX_SLOTS = triuh_pkg::MAX_SLOTS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_type,
   input  wire logic signed [triuh_pkg::AMT_W-1:0]  req_incoming,
   input  wire logic signed [triuh_pkg::AMT_W-1:0]  req_delivered,
   input  wire logic signed [triuh_pkg::AMT_W-1:0]  req_content,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [triuh_pkg::AMT_W-1:0]       rsp_rate,
   output logic signed [triuh_pkg::AMT_W-1:0]       rsp_in_transit,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [triuh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [triuh_pkg::CSR_DATA_W-1:0]    csr_data
);
   localparam int AMT = triuh_pkg::AMT_W;
   localparam int WW  = triuh_pkg::WGT_W;
   localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int JW  = $clog2(MAX_SLOTS + 1);
   localparam int BW  = 16 + JW;
   localparam int NW  = (32 + JW > 40) ? 32 + JW : 40;
   localparam int DW  = (BW > 24) ? BW : 24;
   localparam int SW  = AMT + JW + 1;
   localparam logic [NW-1:0] ONE_Q  = NW'(65536);
   localparam logic [NW-1:0] LIMIT  = NW'(MAX_SLOTS) << 16;

   typedef enum logic [18:0] {
      S_IDLE   = 19'h00001,
      S_Q_MUL  = 19'h00002,
      S_Q_ADD  = 19'h00004,
      S_A_IN   = 19'h00008,
      S_A_C0   = 19'h00010,
      S_A_C1   = 19'h00020,
      S_A_RD   = 19'h00040,
      S_A_MUL  = 19'h00080,
      S_A_WR   = 19'h00100,
      S_A_LAST = 19'h00200,
      S_A_FIN  = 19'h00400,
      S_RB_DIV = 19'h00800,
      S_RB_BAS = 19'h01000,
      S_RB_J   = 19'h02000,
      S_RB_DW  = 19'h04000,
      S_RB_SQ  = 19'h08000,
      S_RB_C   = 19'h10000,
      S_RB_W   = 19'h20000,
      S_DONE   = 19'h40000
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic [triuh_pkg::MAXBAS_W-1:0] maxbas_ff;
   logic [triuh_pkg::STEP_W-1:0]   step_ff;
   logic                           init_ff;
   logic                           kind_ff;
   logic signed [AMT-1:0] inc_ff, dl_ff, ct_ff;
   logic signed [AMT-1:0] prev_ff, inflow_ff, carry_ff, s0_ff, s0new_ff;
   logic signed [AMT-1:0] transit_ff, rate_ff;
   logic signed [SW-1:0]  sum_ff;
   logic [WW-1:0]         w0_ff;
   logic [BW-1:0]         base_ff;
   logic [JW-1:0]         n_ff;
   logic [JW-1:0]         idx_ff;
   logic [16:0]           r_ff, c_ff, cprev_ff;
   logic signed [49:0]    prod_ff;

   logic signed [AMT-1:0] rsp_rate_ff, rsp_transit_ff;
   logic                  rsp_valid_ff;

   // shared multiplier
   logic signed [17:0]    mul_a;
   logic signed [31:0]    mul_b;
   logic signed [33:0]    mulw;
   logic [16:0]           sq_op;

   // memories
   logic                  s_we, w_we;
   logic [AW-1:0]         s_waddr, w_waddr;
   logic signed [AMT-1:0] s_wdata;
   logic [WW-1:0]         w_wdata;
   logic [AMT-1:0]        s_rdata;
   logic [WW-1:0]         w_rdata;

   // divider
   logic                  div_start, div_done;
   logic [NW-1:0]         div_num, div_quo;
   logic [DW-1:0]         div_den;
   logic [triuh_pkg::STEP_W-1:0] step_eff;

   logic signed [AMT-1:0] wr_val, s0_fin, inflow_val, carry_val, rate_val;
   logic [NW-1:0]         j_shift;
   logic                  j_big, j_out;
   logic [NW-1:0]         q_clamp;
   logic [BW:0]           n_round;
   logic [16:0]           c_val;
   logic                  slot_free;
   logic                  csr_hit;

   triuh_ram #(.WIDTH(AMT), .DEPTH(MAX_SLOTS)) u_sched (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (s_rdata)
   );

   triuh_ram #(.WIDTH(WW), .DEPTH(MAX_SLOTS)) u_wgt (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (w_rdata)
   );

   triuh_div #(.NW(NW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign csr_hit   = (csr_index == triuh_pkg::CSR_MAXBAS) ||
                      (csr_index == triuh_pkg::CSR_STEP);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      step_eff = (step_ff == '0) ? triuh_pkg::STEP_ONE_DAY : step_ff;
      j_shift  = NW'(idx_ff) << 16;
      j_big    = j_shift >= NW'(base_ff);
      j_out    = idx_ff > n_ff;

      if (state_ff == S_RB_DIV) begin
         div_num = NW'(maxbas_ff) << 24;
         div_den = DW'(step_eff);
      end else begin
         div_num = NW'(idx_ff) << 32;
         div_den = DW'(base_ff);
      end
      div_start = (state_ff == S_RB_DIV) ||
                  ((state_ff == S_RB_J) && !j_out && !j_big);

      if (div_quo < ONE_Q) begin
         q_clamp = ONE_Q;
      end else if (div_quo > LIMIT) begin
         q_clamp = LIMIT;
      end else begin
         q_clamp = div_quo;
      end
      n_round = (BW + 1)'(q_clamp[BW-1:0]) + (BW + 1)'(65535);

      sq_op = (r_ff <= 17'd32768) ? r_ff : 17'(17'd65536 - r_ff);
      mul_a = 18'sd0;
      mul_b = 32'sd0;
      unique case (state_ff)
         S_Q_MUL: begin
            mul_a = $signed({1'b0, w0_ff});
            mul_b = inc_ff;
         end
         S_A_C0: begin
            mul_a = $signed({1'b0, w0_ff});
            mul_b = inflow_ff;
         end
         S_A_MUL: begin
            mul_a = $signed({1'b0, w_rdata});
            mul_b = inflow_ff;
         end
         S_RB_SQ: begin
            mul_a = $signed({1'b0, sq_op});
            mul_b = $signed(32'(sq_op));
         end
         default: begin
            mul_a = 18'sd0;
         end
      endcase

      mulw       = $signed(prod_ff[49:16]);
      inflow_val = triuh_pkg::sat32(64'(ct_ff) - 64'(prev_ff) + 64'(dl_ff));
      carry_val  = triuh_pkg::sat32(64'(s0_ff) + 64'(mulw) - 64'(dl_ff));
      wr_val     = triuh_pkg::sat32(64'($signed(s_rdata)) + 64'(mulw));
      s0_fin     = triuh_pkg::sat32(64'(s0new_ff) + 64'(carry_ff));
      rate_val   = triuh_pkg::sat32(((s0_ff > 0) ? 64'(s0_ff) : 64'sd0) + 64'(mulw));
      if (r_ff <= 17'd32768) begin
         c_val = prod_ff[31:15];
      end else begin
         c_val = 17'(17'd65536 - prod_ff[31:15]);
      end

      s_we    = 1'b0;
      s_waddr = idx_ff[AW-1:0];
      s_wdata = '0;
      w_we    = 1'b0;
      w_waddr = AW'(idx_ff - 1'b1);
      w_wdata = '0;
      unique case (state_ff)
         S_A_WR: begin
            s_we    = 1'b1;
            s_waddr = AW'(idx_ff - 1'b1);
            s_wdata = wr_val;
         end
         S_A_LAST: begin
            s_we    = 1'b1;
            s_waddr = AW'(MAX_SLOTS - 1);
         end
         S_A_FIN: begin
            s_we    = 1'b1;
            s_waddr = '0;
            s_wdata = s0_fin;
         end
         S_RB_J: begin
            // slots past the triangle are cleared, all of them after reset
            s_we    = j_out || init_ff;
            s_waddr = AW'(idx_ff - 1'b1);
            w_we    = j_out;
         end
         S_RB_W: begin
            w_we    = 1'b1;
            w_wdata = 17'(c_ff - cprev_ff);
         end
         default: begin
            s_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               if (csr_hit) state_in = S_RB_DIV;
            end else if (req_valid) begin
               state_in = (req_type == triuh_pkg::REQ_ADVANCE) ? S_A_IN : S_Q_MUL;
            end
         end
         S_Q_MUL:  state_in = S_Q_ADD;
         S_Q_ADD:  state_in = S_DONE;
         S_A_IN:   state_in = S_A_C0;
         S_A_C0:   state_in = S_A_C1;
         S_A_C1:   state_in = (MAX_SLOTS > 1) ? S_A_RD : S_A_LAST;
         S_A_RD:   state_in = S_A_MUL;
         S_A_MUL:  state_in = S_A_WR;
         S_A_WR:   state_in = (idx_ff == JW'(MAX_SLOTS - 1)) ? S_A_LAST : S_A_RD;
         S_A_LAST: state_in = S_A_FIN;
         S_A_FIN:  state_in = S_DONE;
         S_RB_DIV: state_in = S_RB_BAS;
         S_RB_BAS: if (div_done) state_in = S_RB_J;
         S_RB_J: begin
            if (j_out) begin
               state_in = (idx_ff == JW'(MAX_SLOTS)) ? S_IDLE : S_RB_J;
            end else if (j_big) begin
               state_in = S_RB_W;
            end else begin
               state_in = S_RB_DW;
            end
         end
         S_RB_DW:  if (div_done) state_in = S_RB_SQ;
         S_RB_SQ:  state_in = S_RB_C;
         S_RB_C:   state_in = S_RB_W;
         S_RB_W:   state_in = (idx_ff == JW'(MAX_SLOTS)) ? S_IDLE : S_RB_J;
         S_DONE:   if (slot_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff     <= S_RB_DIV;
         init_ff      <= 1'b1;
         maxbas_ff    <= triuh_pkg::MAXBAS_RESET;
         step_ff      <= triuh_pkg::STEP_RESET;
         prev_ff      <= '0;
         transit_ff   <= '0;
         s0_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= JW'(1);
         idx_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == S_DONE) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (csr_valid) begin
                  if (csr_index == triuh_pkg::CSR_MAXBAS) begin
                     maxbas_ff <= csr_data[triuh_pkg::MAXBAS_W-1:0];
                  end else if (csr_index == triuh_pkg::CSR_STEP) begin
                     step_ff <= csr_data;
                  end
               end else if (req_valid) begin
                  kind_ff <= req_type;
                  inc_ff  <= req_incoming;
                  dl_ff   <= req_delivered;
                  ct_ff   <= req_content;
               end
            end
            S_Q_ADD: rate_ff <= rate_val;
            S_A_IN: begin
               inflow_ff <= inflow_val;
               prev_ff   <= ct_ff;
               rate_ff   <= '0;
            end
            S_A_C1: begin
               carry_ff <= carry_val;
               s0new_ff <= '0;
               sum_ff   <= '0;
               idx_ff   <= JW'(1);
            end
            S_A_WR: begin
               if (idx_ff == JW'(1)) begin
                  s0new_ff <= wr_val;
               end else begin
                  sum_ff <= sum_ff + SW'(wr_val);
               end
               idx_ff <= idx_ff + 1'b1;
            end
            S_A_FIN: begin
               s0_ff      <= s0_fin;
               transit_ff <= triuh_pkg::sat32(64'(sum_ff) + 64'(s0_fin));
            end
            S_RB_BAS: begin
               if (div_done) begin
                  base_ff  <= q_clamp[BW-1:0];
                  n_ff     <= n_round[16 +: JW];
                  idx_ff   <= JW'(1);
                  cprev_ff <= '0;
               end
            end
            S_RB_J: begin
               if (j_out) begin
                  if (idx_ff == JW'(MAX_SLOTS)) begin
                     init_ff <= 1'b0;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else if (j_big) begin
                  c_ff <= 17'd65536;
               end
            end
            S_RB_DW: if (div_done) r_ff <= div_quo[16:0];
            S_RB_C:  c_ff <= c_val;
            S_RB_W: begin
               cprev_ff <= c_ff;
               if (idx_ff == JW'(1)) w0_ff <= 17'(c_ff - cprev_ff);
               if (idx_ff == JW'(MAX_SLOTS)) begin
                  init_ff <= 1'b0;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (slot_free) begin
                  rsp_rate_ff    <= (kind_ff == triuh_pkg::REQ_ADVANCE) ? '0 : rate_ff;
                  rsp_transit_ff <= transit_ff;
               end
            end
            default: begin
               init_ff <= init_ff;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rate       = rsp_rate_ff;
   assign rsp_in_transit = rsp_transit_ff;

   // a word keeps the block busy after it is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after a word was taken");

   // a known register write always starts a weight rebuild
   a_rebuild_on_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_hit) |=> (state_ff == S_RB_DIV))
      else $error("register write did not start a rebuild");

   // the triangle always covers at least one slot and never more than the store
   a_slot_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (n_ff != '0 && n_ff <= JW'(MAX_SLOTS)))
      else $error("slot count out of range");

   // a new result is only loaded into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_in_transit))
      else $error("waiting result was overwritten");
endmodule
`default_nettype wire

FILE: hw/rtl/triuh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triuh_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module triuh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                wr_data,
   input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: hw/rtl/triuh_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triuh_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module triuh_div #(
   parameter int NW = 40,
   parameter int DW = 24
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic     [NW-1:0]  quo
);
   localparam int CW = $clog2(NW + 1);

   logic [DW-1:0] rem_ff;
   logic [NW-1:0] quo_ff;
   logic [DW-1:0] den_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [DW:0]   trial;
   logic          fits;

   always_comb begin
      trial = {rem_ff, quo_ff[NW-1]};
      fits  = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NW);
            rem_ff  <= '0;
            quo_ff  <= num;
            den_ff  <= den;
         end else if (busy_ff) begin
            if (fits) begin
               rem_ff <= DW'(trial - {1'b0, den_ff});
            end else begin
               rem_ff <= trial[DW-1:0];
            end
            quo_ff <= {quo_ff[NW-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule
`default_nettype wire

FILE: tb/tb_triangular_uh_routing_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_triangular_uh_routing_top
// Self-checking bench for the triangular unit hydrograph router: a local
// predictor tracks the schedule and weights, every response word is compared
// field by field with the oldest prediction, both sides idle at random.
// ----------------------------------------------------------------------------
module tb_triangular_uh_routing_top;
   import triuh_pkg::*;

   localparam int SLOTS = MAX_SLOTS_DEF;
   localparam longint CYCLE_LIMIT = 3000000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_type;
   logic signed [AMT_W-1:0] req_incoming;
   logic signed [AMT_W-1:0] req_delivered;
   logic signed [AMT_W-1:0] req_content;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [AMT_W-1:0] rsp_rate;
   logic signed [AMT_W-1:0] rsp_in_transit;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   triangular_uh_routing_top DUT (.*);

   typedef struct packed {
      logic signed [AMT_W-1:0] rate;
      logic signed [AMT_W-1:0] in_transit;
   } route_result_type;

   // predictor state
   logic [MAXBAS_W-1:0] pr_maxbas;
   logic [STEP_W-1:0] pr_step;
   logic signed [AMT_W-1:0] pr_sched [SLOTS];
   logic [WGT_W-1:0] pr_wgt [SLOTS];
   int pr_slots;
   logic signed [AMT_W-1:0] pr_prev_content;
   logic signed [AMT_W-1:0] pr_transit;

   route_result_type expected_results[$];
   int errors;
   int results_seen;
   int queries_sent;
   int advances_sent;
   int configs_done;
   longint cycles;
   bit stall_free;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("triangular_uh_routing_top test failed");
         $finish;
      end
   end

   function automatic logic signed [AMT_W-1:0] clamp_amt(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[AMT_W-1:0];
   endfunction

   // weight times amount, rounded toward minus infinity
   function automatic longint scale_amt(input logic [WGT_W-1:0] w,
                                        input logic signed [AMT_W-1:0] a);
      longint p;
      p = longint'(w) * longint'(a);
      return p >>> 16;
   endfunction

   function automatic longint cum_curve(input longint j, input longint base);
      longint r;
      longint d;
      if (j == 0) return 0;
      if ((j << 16) >= base) return 65536;
      r = (j << 32) / base;
      if (r <= 32768) return (r * r) >> 15;
      d = 65536 - r;
      return 65536 - ((d * d) >> 15);
   endfunction

   function automatic void rebuild_weights();
      longint stp;
      longint base;
      int n;
      stp = (pr_step == 0) ? 65536 : longint'(pr_step);
      base = (longint'(pr_maxbas) << 24) / stp;
      if (base < 65536) base = 65536;
      if (base > (longint'(SLOTS) << 16)) base = longint'(SLOTS) << 16;
      n = int'((base + 65535) >> 16);
      if (n > SLOTS) n = SLOTS;
      for (int j = 0; j < SLOTS; j++) begin
         if (j < n) begin
            pr_wgt[j] = WGT_W'(cum_curve(j + 1, base) - cum_curve(j, base));
         end else begin
            pr_wgt[j] = '0;
            pr_sched[j] = '0;
         end
      end
      pr_slots = n;
   endfunction

   function automatic route_result_type predict_route(input logic kind,
         input logic signed [AMT_W-1:0] inc, input logic signed [AMT_W-1:0] dlv,
         input logic signed [AMT_W-1:0] cnt);
      route_result_type res;
      logic signed [AMT_W-1:0] inflow;
      logic signed [AMT_W-1:0] carry;
      longint s0;
      longint total;
      res.rate = '0;
      if (kind == REQ_QUERY) begin
         s0 = (pr_sched[0] > 0) ? longint'(pr_sched[0]) : 0;
         res.rate = clamp_amt(s0 + scale_amt(pr_wgt[0], inc));
      end else begin
         inflow = clamp_amt(longint'(cnt) - longint'(pr_prev_content) + longint'(dlv));
         pr_prev_content = cnt;
         carry = clamp_amt(longint'(pr_sched[0]) + scale_amt(pr_wgt[0], inflow)
                           - longint'(dlv));
         for (int j = 0; j + 1 < SLOTS; j++)
            pr_sched[j] = clamp_amt(longint'(pr_sched[j + 1])
                                    + scale_amt(pr_wgt[j + 1], inflow));
         pr_sched[SLOTS - 1] = '0;
         pr_sched[0] = clamp_amt(longint'(pr_sched[0]) + longint'(carry));
         total = 0;
         for (int j = 0; j < SLOTS; j++) total += longint'(pr_sched[j]);
         pr_transit = clamp_amt(total);
      end
      res.in_transit = pr_transit;
      return res;
   endfunction

   function automatic bit idle_now();
      return !stall_free && ($urandom_range(99) < 20);
   endfunction

   // valid stays up after acceptance until the next idle cycle or drain
   task automatic send_item(input logic kind, input logic signed [AMT_W-1:0] inc,
                            input logic signed [AMT_W-1:0] dlv,
                            input logic signed [AMT_W-1:0] cnt);
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_incoming <= inc;
      req_delivered <= dlv;
      req_content <= cnt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(predict_route(kind, inc, dlv, cnt));
      if (kind == REQ_QUERY) queries_sent++;
      else advances_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_MAXBAS) pr_maxbas = val[MAXBAS_W-1:0];
      else if (idx == CSR_STEP) pr_step = val[STEP_W-1:0];
      if (idx == CSR_MAXBAS || idx == CSR_STEP) rebuild_weights();
      configs_done++;
   endtask

   // response side: random backpressure, compare with oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected word rate=%0d in_transit=%0d",
                        $time, rsp_rate, rsp_in_transit);
               errors++;
            end else begin
               route_result_type e;
               e = expected_results.pop_front();
               if (rsp_rate !== e.rate) begin
                  $display("%0t: rate expected %0d actual %0d", $time, e.rate, rsp_rate);
                  errors++;
               end
               if (rsp_in_transit !== e.in_transit) begin
                  $display("%0t: in_transit expected %0d actual %0d",
                           $time, e.in_transit, rsp_in_transit);
                  errors++;
               end
            end
            results_seen++;
         end
         rsp_ready <= !idle_now();
      end
   end

   function automatic logic signed [AMT_W-1:0] rand_amt();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom;
         default: return AMT_W'($signed($urandom_range(400000)) - 200000);
      endcase
   endfunction

   task automatic test_directed();
      send_item(REQ_QUERY, 32'sh7fffffff, 0, 0);
      send_item(REQ_QUERY, 32'sh80000000, 0, 0);
      send_item(REQ_ADVANCE, 0, 32'sh10000, 32'sh50000);
      send_item(REQ_QUERY, 32'sh10000, 0, 0);
      write_reg(CSR_MAXBAS, 24'h0400);
      send_item(REQ_ADVANCE, 0, 32'sh7fffffff, 32'sh7fffffff);
      send_item(REQ_ADVANCE, 0, 32'sh80000000, 32'sh80000000);
      send_item(REQ_QUERY, 32'shffffffff, 0, 0);
      send_item(REQ_ADVANCE, 0, 0, 32'sh20000);
      send_item(REQ_ADVANCE, 0, 32'sh8000, 32'sh18000);
      write_reg(CSR_STEP, 24'd0);
      send_item(REQ_ADVANCE, 32'sh7fffffff, 0, 32'sh30000);
      write_reg(8'd7, 24'hffffff);
      send_item(REQ_QUERY, 32'sh12345, 0, 0);
      write_reg(CSR_MAXBAS, 24'h0001);
      send_item(REQ_ADVANCE, 0, 32'sh100, 32'sh100);
      write_reg(CSR_MAXBAS, 24'hffff);
      send_item(REQ_ADVANCE, 0, 0, 32'sh40000);
      send_item(REQ_QUERY, 32'sh40000, 0, 0);
      write_reg(CSR_STEP, 24'hffffff);
      send_item(REQ_ADVANCE, 0, 32'shffff0000, 32'sh0);
   endtask

   task automatic test_random_routing(input int count);
      logic signed [AMT_W-1:0] level;
      level = pr_prev_content;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(2) == 0) begin
            send_item(REQ_QUERY, rand_amt(), $urandom, $urandom);
         end else if ($urandom_range(4) == 0) begin
            send_item(REQ_ADVANCE, $urandom, rand_amt(), rand_amt());
         end else begin
            // plausible store: content drifts slowly
            level = clamp_amt(longint'(level) + $signed($urandom_range(200000)) - 100000);
            send_item(REQ_ADVANCE, $urandom,
                      AMT_W'($urandom_range(80000)), level);
         end
      end
   endtask

   initial begin
      cycles = 0;
      errors = 0;
      results_seen = 0;
      queries_sent = 0;
      advances_sent = 0;
      configs_done = 0;
      stall_free = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_QUERY;
      req_incoming = '0;
      req_delivered = '0;
      req_content = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      pr_maxbas = MAXBAS_RESET;
      pr_step = STEP_RESET;
      pr_prev_content = '0;
      pr_transit = '0;
      for (int j = 0; j < SLOTS; j++) pr_sched[j] = '0;
      rebuild_weights();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      write_reg(CSR_STEP, 24'h010000);
      write_reg(CSR_MAXBAS, 24'h0380);
      test_random_routing(100);
      stall_free = 1'b1;
      test_random_routing(60);
      stall_free = 1'b0;
      write_reg(CSR_MAXBAS, 24'h0100);
      write_reg(CSR_STEP, 24'h020000);
      test_random_routing(80);
      write_reg(CSR_MAXBAS, 24'h2000);
      write_reg(CSR_STEP, 24'h004000);
      test_random_routing(60);
      write_reg(CSR_MAXBAS, CSR_DATA_W'($urandom_range(2048)));
      write_reg(CSR_STEP, CSR_DATA_W'($urandom_range(24'hffffff)));
      test_random_routing(80);

      drain_results();
      $display("covered %0d queries, %0d advances, %0d register writes, %0d words checked",
               queries_sent, advances_sent, configs_done, results_seen);
      if (errors == 0) begin
         $display("triangular_uh_routing_top test passed");
      end else begin
         $display("triangular_uh_routing_top test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
